@@ design/dmrsd_pkg.sv @@
`default_nettype none
package dmrsd_pkg;

	localparam logic [1:0] OP_REQ  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	localparam int DIV_BITS = 10;
	localparam logic [3:0] DIV_TOP = 4'd9;
	localparam logic [9:0] DUTY_SCALE = 10'd1000;
	// ceil(2^37 / 1000), exact for products below 2^27
	localparam logic [27:0] RECIP_1000 = 28'd137438954;
	localparam int RECIP_SHIFT = 37;

	localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
	localparam logic [2:0] REG_DUTY_FLOOR  = 3'd1;
	localparam logic [2:0] REG_DUTY_CEIL   = 3'd2;
	localparam logic [2:0] REG_GAIN        = 3'd3;
	localparam logic [2:0] REG_CORR_LIMIT  = 3'd4;
	localparam logic [2:0] REG_RAMP_STEP   = 3'd5;
	localparam logic [2:0] REG_PERIOD      = 3'd6;
	localparam logic [2:0] REG_MODE        = 3'd7;

	typedef struct packed {
		logic [14:0] speed_limit;
		logic [9:0]  duty_floor;
		logic [9:0]  duty_ceiling;
		logic [9:0]  gain;
		logic [9:0]  correction_limit;
		logic [9:0]  ramp_step;
		logic [15:0] pwm_period;
		logic [2:0]  mode_bits;
	} cfg_t;

	typedef struct packed {
		logic       latch;
		logic       dec;
		logic       divi;
		logic       divs;
		logic       corr;
		logic       goal;
		logic       tick;
		logic       m1;
		logic       m2;
		logic       cw;
		logic       side;
		logic [3:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       rej;
		logic       updated;
	} stat_t;

endpackage
`default_nettype wire

@@ design/dual_motor_ramped_speed_drive_core.sv @@
// Two-motor ramped speed drive.
// Input channel (in_valid/in_stall) carries one item: op plus target and
// measured speeds. op 0 requests speeds, 1 is a one millisecond tick, 2 stops.
// Output channel (out_valid/out_stall) returns one item per input item:
// status, updated, the four held compare counts and bridge_enable.
// Sequencing: a request runs a 10-step restoring divider per side, then a
// multiply and clamp per side; a tick ramps both sides and, with a refresh,
// runs two multiplies per side for the compare counts; stop, a rejected
// request and an unused op go straight from decode to output.
// One item is worked at a time; in_stall stays high from accept until the
// result is taken, so a new item is not accepted before the last is done.
// While out_stall is high the result is held unchanged.
// Reset clears all drive state and loads the register defaults; the block
// is ready in the first cycle after reset.
// Registers are written over the APB port at byte address 4*index.
`default_nettype none
module dual_motor_ramped_speed_drive_core
	import dmrsd_pkg::*;
#(
	parameter logic [7:0]  UPDATE_TICKS = 8'd1,
	parameter logic [15:0] SETTLE_TICKS = 16'd100
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [4:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [1:0]  op,
	input  wire logic signed [15:0] left_speed,
	input  wire logic signed [15:0] right_speed,
	input  wire logic signed [15:0] left_measured,
	input  wire logic signed [15:0] right_measured,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    status,
	output logic                    updated,
	output logic             [15:0] left_fwd_counts,
	output logic             [15:0] left_rev_counts,
	output logic             [15:0] right_fwd_counts,
	output logic             [15:0] right_rev_counts,
	output logic                    bridge_enable
);
	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	dmrsd_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	dmrsd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
	);

	dmrsd_dpath #(
		.UPDATE_TICKS(UPDATE_TICKS),
		.SETTLE_TICKS(SETTLE_TICKS)
	) u_dpath (
		.clk, .arst_n, .cfg, .cmd, .st,
		.op, .left_speed, .right_speed, .left_measured, .right_measured,
		.status, .updated, .left_fwd_counts, .left_rev_counts,
		.right_fwd_counts, .right_rev_counts, .bridge_enable
	);
endmodule
`default_nettype wire

@@ design/dmrsd_regs.sv @@
`default_nettype none
module dmrsd_regs
	import dmrsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit      <= 15'd300;
			cfg_q.duty_floor       <= 10'd0;
			cfg_q.duty_ceiling     <= 10'd1000;
			cfg_q.gain             <= 10'd1;
			cfg_q.correction_limit <= 10'd200;
			cfg_q.ramp_step        <= 10'd5;
			cfg_q.pwm_period       <= 16'd10000;
			cfg_q.mode_bits        <= 3'd1;
		end else if (wr) begin
			case (paddr[4:2])
				REG_SPEED_LIMIT: cfg_q.speed_limit      <= pwdata[14:0];
				REG_DUTY_FLOOR:  cfg_q.duty_floor       <= pwdata[9:0];
				REG_DUTY_CEIL:   cfg_q.duty_ceiling     <= pwdata[9:0];
				REG_GAIN:        cfg_q.gain             <= pwdata[9:0];
				REG_CORR_LIMIT:  cfg_q.correction_limit <= pwdata[9:0];
				REG_RAMP_STEP:   cfg_q.ramp_step        <= pwdata[9:0];
				REG_PERIOD:      cfg_q.pwm_period       <= pwdata[15:0];
				REG_MODE:        cfg_q.mode_bits        <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SPEED_LIMIT: prdata = {17'd0, cfg_q.speed_limit};
			REG_DUTY_FLOOR:  prdata = {22'd0, cfg_q.duty_floor};
			REG_DUTY_CEIL:   prdata = {22'd0, cfg_q.duty_ceiling};
			REG_GAIN:        prdata = {22'd0, cfg_q.gain};
			REG_CORR_LIMIT:  prdata = {22'd0, cfg_q.correction_limit};
			REG_RAMP_STEP:   prdata = {22'd0, cfg_q.ramp_step};
			REG_PERIOD:      prdata = {16'd0, cfg_q.pwm_period};
			REG_MODE:        prdata = {29'd0, cfg_q.mode_bits};
			default:         prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

@@ design/dmrsd_ctrl.sv @@
`default_nettype none
module dmrsd_ctrl
	import dmrsd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  stat_t     st,
	output cmd_t      cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_DIVI = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_CORR = 4'd4;
	localparam logic [3:0] S_GOAL = 4'd5;
	localparam logic [3:0] S_TICK = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_CW   = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       side_q, side_d;
	logic [3:0] bit_q, bit_d;
	logic       acc;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid & ~in_stall;

	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		bit_d   = bit_q;
		cmd     = '0;
		cmd.side    = side_q;
		cmd.bit_idx = bit_q;
		case (state_q)
			S_IDLE: begin
				cmd.latch = acc;
				if (acc) state_d = S_DEC;
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				side_d = 1'b0;
				case (st.op)
					OP_REQ:  state_d = st.rej ? S_OUT : S_DIVI;
					OP_TICK: state_d = S_TICK;
					default: state_d = S_OUT;
				endcase
			end
			S_DIVI: begin
				cmd.divi = 1'b1;
				bit_d = DIV_TOP;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.divs = 1'b1;
				bit_d = bit_q - 4'd1;
				if (bit_q == 4'd0) state_d = S_CORR;
			end
			S_CORR: begin
				cmd.corr = 1'b1;
				state_d = S_GOAL;
			end
			S_GOAL: begin
				cmd.goal = 1'b1;
				side_d = 1'b1;
				state_d = side_q ? S_OUT : S_DIVI;
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d = st.updated ? S_M1 : S_OUT;
			end
			S_M1: begin
				cmd.m1 = 1'b1;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.m2 = 1'b1;
				state_d = S_CW;
			end
			S_CW: begin
				cmd.cw = 1'b1;
				side_d = 1'b1;
				state_d = side_q ? S_OUT : S_M1;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q  <= 1'b0;
			bit_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			bit_q   <= bit_d;
		end
	end

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == S_DEC))
		else $error("accepted item did not enter decode");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (state_q == S_IDLE))
		else $error("result taken but block not idle");
	a_div_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (bit_q <= DIV_TOP))
		else $error("divider bit index out of range");
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
endmodule
`default_nettype wire

@@ design/dmrsd_dpath.sv @@
`default_nettype none
module dmrsd_dpath
	import dmrsd_pkg::*;
#(
	parameter logic [7:0]  UPDATE_TICKS = 8'd1,
	parameter logic [15:0] SETTLE_TICKS = 16'd100
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cfg_t                    cfg,
	input  cmd_t                    cmd,
	output stat_t                   st,
	input  wire logic        [1:0]  op,
	input  wire logic signed [15:0] left_speed,
	input  wire logic signed [15:0] right_speed,
	input  wire logic signed [15:0] left_measured,
	input  wire logic signed [15:0] right_measured,
	output logic                    status,
	output logic                    updated,
	output logic             [15:0] left_fwd_counts,
	output logic             [15:0] left_rev_counts,
	output logic             [15:0] right_fwd_counts,
	output logic             [15:0] right_rev_counts,
	output logic                    bridge_enable
);
	logic        [1:0]  op_q;
	logic signed [15:0] ls_q, rs_q, lm_q, rm_q;
	logic signed [15:0] ltgt_q, rtgt_q;
	logic signed [10:0] lgoal_q, rgoal_q, lapp_q, rapp_q;
	logic        [7:0]  tick_q;
	logic        [15:0] settle_q;
	logic        [15:0] held_q [4];
	logic               en_q, status_q, updated_q, ready_q;
	logic        [25:0] rem_q;
	logic        [9:0]  quo_q;
	logic               sat_q, neg_q, zero_q;
	logic        [9:0]  bmag_q;
	logic signed [28:0] prod_q;
	logic        [25:0] p1_q;
	logic        [53:0] p2_q;

	logic               rej;
	logic signed [15:0] lim_s;
	logic        [14:0] div_lim;
	logic signed [15:0] rpm, meas;
	logic               rev;
	logic signed [16:0] sv;
	logic        [15:0] smag;
	logic        [25:0] num, dsh;
	logic        [10:0] dq;
	logic        [9:0]  dmag;
	logic signed [17:0] md, diff;
	logic signed [28:0] prod;
	logic signed [11:0] climp, corr, m;
	logic        [9:0]  mmag, gmag;
	logic               use_fb;
	logic signed [10:0] goal;
	logic signed [10:0] app;
	logic        [9:0]  amag;
	logic        [16:0] cnt;
	logic        [15:0] cnt_sat;
	logic        [7:0]  tick_n;

	function automatic logic signed [10:0] ramp(input logic signed [10:0] cur,
		input logic signed [10:0] g, input logic [9:0] step);
		logic signed [12:0] n;
		begin
			n = 13'sd0;
			if (cur < g) begin
				n = 13'(cur) + $signed({3'b0, step});
				ramp = (n > 13'(g)) ? g : n[10:0];
			end else if (cur > g) begin
				n = 13'(cur) - $signed({3'b0, step});
				ramp = (n < 13'(g)) ? g : n[10:0];
			end else begin
				ramp = cur;
			end
		end
	endfunction

	assign lim_s = $signed({1'b0, cfg.speed_limit});
	assign rej = (ls_q < -lim_s) || (ls_q > lim_s) || (rs_q < -lim_s) || (rs_q > lim_s);
	assign st.op = op_q;
	assign st.rej = rej;
	assign st.updated = updated_q;

	assign div_lim = (cfg.speed_limit == 15'd0) ? 15'd1 : cfg.speed_limit;
	assign rpm  = cmd.side ? rtgt_q : ltgt_q;
	assign meas = cmd.side ? rm_q : lm_q;
	assign rev  = cmd.side ? cfg.mode_bits[2] : cfg.mode_bits[1];
	assign sv   = rev ? -17'(rpm) : 17'(rpm);
	assign smag = sv[16] ? 16'(-sv) : sv[15:0];
	assign num  = 26'(smag) * 26'(DUTY_SCALE);
	assign dsh  = 26'({11'd0, div_lim} << cmd.bit_idx);
	assign tick_n = tick_q + 8'd1;

	always_comb begin
		dq = sat_q ? 11'd1024 : {1'b0, quo_q};
		if (dq < {1'b0, cfg.duty_floor}) dq = {1'b0, cfg.duty_floor};
		if (dq > {1'b0, cfg.duty_ceiling}) dq = {1'b0, cfg.duty_ceiling};
		dmag = zero_q ? 10'd0 : dq[9:0];
	end

	assign md   = (rpm < 0) ? -18'(meas) : 18'(meas);
	assign diff = 18'(rpm < 0 ? -17'(rpm) : 17'(rpm)) - md;
	assign prod = 29'(diff) * $signed({19'b0, cfg.gain});

	always_comb begin
		climp = $signed({2'b0, cfg.correction_limit});
		if (prod_q > 29'(climp)) corr = climp;
		else if (prod_q < -29'(climp)) corr = -climp;
		else corr = prod_q[11:0];
		m = $signed({2'b0, bmag_q}) + corr;
		if (m < $signed({2'b0, cfg.duty_floor})) mmag = cfg.duty_floor;
		else if (m > $signed({2'b0, cfg.duty_ceiling})) mmag = cfg.duty_ceiling;
		else mmag = m[9:0];
		use_fb = cfg.mode_bits[0] & ready_q & (rpm != 16'sd0);
		gmag = use_fb ? mmag : bmag_q;
		goal = neg_q ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
	end

	assign app  = cmd.side ? rapp_q : lapp_q;
	assign amag = app[10] ? 10'(-app) : app[9:0];
	assign cnt  = p2_q[RECIP_SHIFT+16:RECIP_SHIFT];
	assign cnt_sat = cnt[16] ? 16'hFFFF : cnt[15:0];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= op;
			ls_q <= left_speed;
			rs_q <= right_speed;
			lm_q <= left_measured;
			rm_q <= right_measured;
		end
		if (cmd.divi) begin
			rem_q  <= num;
			quo_q  <= '0;
			sat_q  <= num >= {1'b0, div_lim, 10'd0};
			neg_q  <= sv[16];
			zero_q <= (sv == 17'sd0);
		end
		if (cmd.divs && rem_q >= dsh) begin
			rem_q <= rem_q - dsh;
			quo_q[cmd.bit_idx] <= 1'b1;
		end
		if (cmd.corr) begin
			prod_q <= prod;
			bmag_q <= dmag;
			neg_q  <= neg_q & (dmag != 10'd0);
		end
		if (cmd.m1) p1_q <= 26'(cfg.pwm_period) * 26'(amag);
		if (cmd.m2) p2_q <= 54'(p1_q) * 54'(RECIP_1000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltgt_q <= '0; rtgt_q <= '0;
			lgoal_q <= '0; rgoal_q <= '0;
			lapp_q <= '0; rapp_q <= '0;
			tick_q <= '0; settle_q <= '0;
			for (int i = 0; i < 4; i++) held_q[i] <= '0;
			en_q <= 1'b0; status_q <= 1'b0; updated_q <= 1'b0; ready_q <= 1'b0;
		end else begin
			if (cmd.dec) begin
				status_q  <= (op_q == OP_REQ) & rej;
				updated_q <= (op_q == OP_STOP) |
					((op_q == OP_TICK) & (tick_n >= UPDATE_TICKS));
				case (op_q)
					OP_REQ: begin
						if (!rej) begin
							ltgt_q <= ls_q;
							rtgt_q <= rs_q;
							if (ls_q != ltgt_q || rs_q != rtgt_q) begin
								settle_q <= '0;
								ready_q  <= (SETTLE_TICKS == 16'd0);
							end else begin
								ready_q <= (settle_q >= SETTLE_TICKS);
							end
						end
					end
					OP_STOP: begin
						ltgt_q <= '0; rtgt_q <= '0;
						lgoal_q <= '0; rgoal_q <= '0;
						lapp_q <= '0; rapp_q <= '0;
						tick_q <= '0; settle_q <= '0;
						for (int i = 0; i < 4; i++) held_q[i] <= '0;
						en_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.goal) begin
				if (cmd.side) rgoal_q <= goal;
				else lgoal_q <= goal;
			end
			if (cmd.tick) begin
				if (ltgt_q != 16'sd0 || rtgt_q != 16'sd0) begin
					if (settle_q < SETTLE_TICKS) settle_q <= settle_q + 16'd1;
				end else begin
					settle_q <= '0;
				end
				lapp_q <= ramp(lapp_q, lgoal_q, cfg.ramp_step);
				rapp_q <= ramp(rapp_q, rgoal_q, cfg.ramp_step);
				tick_q <= (tick_n >= UPDATE_TICKS) ? 8'd0 : tick_n;
			end
			if (cmd.cw) begin
				held_q[{cmd.side, 1'b0}] <= (app > 11'sd0) ? cnt_sat : 16'd0;
				held_q[{cmd.side, 1'b1}] <= (app < 11'sd0) ? cnt_sat : 16'd0;
				en_q <= (lapp_q != 11'sd0) || (rapp_q != 11'sd0);
			end
		end
	end

	assign status           = status_q;
	assign updated          = updated_q;
	assign left_fwd_counts  = held_q[0];
	assign left_rev_counts  = held_q[1];
	assign right_fwd_counts = held_q[2];
	assign right_rev_counts = held_q[3];
	assign bridge_enable    = en_q;
endmodule
`default_nettype wire
